// ===== hw/rtl/ecpu_pkg.sv =====
// Shared types, opcodes and write-port struct for the 8-bit instruction step block.
package ecpu_pkg;

	typedef logic [15:0] word_t;
	typedef logic [7:0]  byte_t;
	typedef logic [3:0]  ridx_t;

	localparam int unsigned NumRegs = 16;
	localparam int unsigned MemBytes = 256;

	localparam byte_t AluResetVal = 8'hFF;

	// Top nibble of the instruction word
	typedef enum logic [3:0] {
		OP_LDI = 4'h0,
		OP_ADD = 4'h1,
		OP_SUB = 4'h2,
		OP_JMP = 4'hA,
		OP_JZ  = 4'hB,
		OP_LD  = 4'hC,
		OP_ST  = 4'hD
	} opcode_t;

	// Register file write port
	typedef struct packed {
		logic  en;
		ridx_t idx;
		byte_t val;
	} rf_wr_t;

endpackage

// ===== hw/rtl/ecpu_rf.sv =====
// Sixteen-entry register file: two registered read ports, one write port, reset by valid bits.
module ecpu_rf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  ecpu_pkg::ridx_t rd_addr_a,
	input  ecpu_pkg::ridx_t rd_addr_b,
	output ecpu_pkg::byte_t rd_data_a,
	output ecpu_pkg::byte_t rd_data_b,
	input  ecpu_pkg::rf_wr_t wr
);
	import ecpu_pkg::*;

	byte_t               ram [NumRegs];
	logic  [NumRegs-1:0] vld_q;
	byte_t               ram_a_q;
	byte_t               ram_b_q;
	logic                va_q;
	logic                vb_q;

	// Storage: write and registered reads
	always_ff @(posedge clk) begin
		if (wr.en) begin
			ram[wr.idx] <= wr.val;
		end
		if (rd_en) begin
			ram_a_q <= ram[rd_addr_a];
			ram_b_q <= ram[rd_addr_b];
		end
	end

	// Written flags; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			va_q <= vld_q[rd_addr_a];
			vb_q <= vld_q[rd_addr_b];
		end
	end

	assign rd_data_a = va_q ? ram_a_q : '0;
	assign rd_data_b = vb_q ? ram_b_q : '0;

endmodule

// ===== hw/rtl/eight_bit_cpu_instruction_step_top.sv =====
// Top level of the 8-bit instruction step block: fetch of operands, execute and write-back.

// Executes one 16-bit instruction per transfer and sustains one instruction per clock
// while the output is not stalled. An accepted instruction reads the register file (two
// ports) and the 256-byte data memory in the cycle of its transfer; it then executes in
// stage 1 and, as it leaves execute, writes back and updates the program counter and
// last-ALU byte. The result is loaded into the output register as the instruction leaves
// execute. A write made by the preceding instruction is forwarded to the following one,
// so back-to-back dependent instructions run at full rate. Both memories come out of
// reset as all zero at once through per-entry written flags; no clearing pass is needed.
// Only output back-pressure stops the input side.
module eight_bit_cpu_instruction_step_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ecpu_pkg::word_t instruction,
	output logic            out_valid,
	input  logic            out_ready,
	output ecpu_pkg::word_t next_pc,
	output logic            reg_write,
	output ecpu_pkg::ridx_t reg_index,
	output ecpu_pkg::byte_t reg_value,
	output logic            mem_write,
	output ecpu_pkg::byte_t mem_addr,
	output ecpu_pkg::byte_t mem_value,
	output ecpu_pkg::byte_t alu_byte
);
	import ecpu_pkg::*;

	// Architectural scalars
	word_t pc_q;
	byte_t alu_q;

	// Stage 1 (execute) registers
	logic  s1_v_q;
	word_t instr_s1;
	logic  byp_a_s1, byp_b_s1, dm_byp_s1;
	byte_t bypv_a_s1, bypv_b_s1, dm_bypv_s1;
	byte_t dm_ram_s1;
	logic  dm_va_s1;

	// Data memory and written flags
	byte_t                dmem [MemBytes];
	logic  [MemBytes-1:0] dm_vld_q;

	// Handshake
	logic in_xfer, s1_adv;
	assign s1_adv   = s1_v_q && (!out_valid || out_ready);
	assign in_ready = !s1_v_q || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	// Input decode for the operand reads
	opcode_t in_op;
	ridx_t   in_ra, in_rb;
	byte_t   in_kk;
	assign in_op = opcode_t'(instruction[15:12]);
	assign in_ra = (in_op == OP_ST) ? instruction[11:8] : instruction[7:4];
	assign in_rb = instruction[3:0];
	assign in_kk = instruction[7:0];

	// Execute stage fields
	opcode_t op_s1;
	ridx_t   d_s1;
	byte_t   kk_s1;
	word_t   nnn_s1;
	byte_t   rd_a, rd_b, opa, opb, dm_rd;
	assign op_s1  = opcode_t'(instr_s1[15:12]);
	assign d_s1   = instr_s1[11:8];
	assign kk_s1  = instr_s1[7:0];
	assign nnn_s1 = {4'b0000, instr_s1[11:0]};

	rf_wr_t rf_wr;

	ecpu_rf u_rf (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_xfer),
		.rd_addr_a (in_ra),
		.rd_addr_b (in_rb),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b),
		.wr        (rf_wr)
	);

	// Operands with forwarding from the instruction that left execute at the read edge
	assign opa   = byp_a_s1 ? bypv_a_s1 : rd_a;
	assign opb   = byp_b_s1 ? bypv_b_s1 : rd_b;
	assign dm_rd = dm_byp_s1 ? dm_bypv_s1 : (dm_va_s1 ? dm_ram_s1 : '0);

	// Execute
	word_t pc_n;
	byte_t alu_n, rv;
	logic  rw, mw;
	always_comb begin
		pc_n  = pc_q + 16'd1;
		alu_n = alu_q;
		rv    = '0;
		rw    = 1'b0;
		mw    = 1'b0;
		unique case (op_s1)
			OP_LDI: begin
				rw = 1'b1;
				rv = kk_s1;
			end
			OP_ADD: begin
				rw    = 1'b1;
				rv    = opa + opb;
				alu_n = rv;
			end
			OP_SUB: begin
				rw    = 1'b1;
				rv    = opa - opb;
				alu_n = rv;
			end
			OP_JMP: begin
				pc_n = nnn_s1;
			end
			OP_JZ: begin
				if (alu_q == '0) begin
					pc_n  = nnn_s1;
					alu_n = AluResetVal;
				end
			end
			OP_LD: begin
				rw = 1'b1;
				rv = dm_rd;
			end
			OP_ST: begin
				mw = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign rf_wr.en  = s1_adv && rw;
	assign rf_wr.idx = d_s1;
	assign rf_wr.val = rv;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_ready) begin
			s1_v_q <= in_valid;
		end
	end

	// Stage 1 payload and forwarding flags, captured on the input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			instr_s1   <= instruction;
			byp_a_s1   <= rf_wr.en && (d_s1 == in_ra);
			byp_b_s1   <= rf_wr.en && (d_s1 == in_rb);
			bypv_a_s1  <= rv;
			bypv_b_s1  <= rv;
			dm_byp_s1  <= s1_adv && mw && (kk_s1 == in_kk);
			dm_bypv_s1 <= opa;
			dm_va_s1   <= dm_vld_q[in_kk];
		end
	end

	// Data memory: store from execute, registered read on transfer
	always_ff @(posedge clk) begin
		if (s1_adv && mw) begin
			dmem[kk_s1] <= opa;
		end
		if (in_xfer) begin
			dm_ram_s1 <= dmem[in_kk];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dm_vld_q <= '0;
		end else if (s1_adv && mw) begin
			dm_vld_q[kk_s1] <= 1'b1;
		end
	end

	// Program counter and last-ALU byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			alu_q <= AluResetVal;
		end else if (s1_adv) begin
			pc_q  <= pc_n;
			alu_q <= alu_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			next_pc   <= pc_n;
			reg_write <= rw;
			reg_index <= rw ? d_s1 : '0;
			reg_value <= rw ? rv : '0;
			mem_write <= mw;
			mem_addr  <= mw ? kk_s1 : '0;
			mem_value <= mw ? opa : '0;
			alu_byte  <= alu_n;
		end
	end

`ifndef SYNTHESIS
	// A taken conditional jump sets the last-ALU byte back to its reset value
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && op_s1 == OP_JZ && alu_q == '0) |=> (alu_q == AluResetVal))
		else $error("conditional jump did not restore last-ALU byte");

	// An instruction leaving execute is visible at the output next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> (out_valid && next_pc == pc_q))
		else $error("execute result lost or program counter mismatch");

	// Reported register and memory writes never coexist
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reg_write && mem_write))
		else $error("register and memory write in one result");

	// Unused memory write fields read as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mem_write) |-> (mem_addr == '0 && mem_value == '0))
		else $error("memory fields not cleared without a store");
`endif

endmodule
